// ===== sv/c2op_pkg.sv =====
// Package for the 2D convolution output-point block.
// Holds opcode and register index codes, the request layout, the state type and the MAC control
// struct. It has no dependencies.
package c2op_pkg;

   // Field widths fixed by the request and response formats.
   localparam int VALUE_W    = 16;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 40;
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;
   localparam int REQ_FIELDS_W = 34;

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      OP_WEIGHT  = 2'd0,
      OP_BIAS    = 2'd1,
      OP_PIXEL   = 2'd2,
      OP_COMPUTE = 2'd3
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_IN_CHANNELS  = 3'd0,
      CSR_OUT_CHANNELS = 3'd1,
      CSR_KERNEL_SIDE  = 3'd2,
      CSR_STEP_SIZE    = 3'd3,
      CSR_ZERO_BORDER  = 3'd4,
      CSR_IMAGE_HEIGHT = 3'd5,
      CSR_IMAGE_WIDTH  = 3'd6,
      CSR_BIAS_ENABLE  = 3'd7
   } csr_index_type;

   // Request payload, out_channel in the lowest bits.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [4:0]                column;
      logic [4:0]                row;
      logic [3:0]                in_channel;
      logic [3:0]                out_channel;
   } req_fields_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_WAIT  = 4'b1000
   } state_type;

   // Control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic clear;    // load the accumulator with the start value
      logic tap_vld;  // the registered pixel and weight belong to a tap inside the image
      logic acc_en;   // add the registered product
   } mac_ctrl_type;

endpackage

// ===== sv/c2op_mac.sv =====
// Multiply-accumulate unit of the convolution block.
// One registered 16x16 product per cycle feeding a 40-bit accumulator.
// Depends on c2op_pkg.
module c2op_mac import c2op_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] pixel,
   input  logic signed [VALUE_W-1:0] weight,
   input  logic signed [SUM_W-1:0]  init,
   output logic signed [SUM_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_full;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  acc_in;

   // Taps outside the image contribute zero.
   assign prod_full = pixel * weight;
   assign prod_in   = ctrl.tap_vld ? prod_full : '0;

   // Accumulate one product per cycle while acc_en is set; clear loads the start value instead.
   always_comb begin
      priority if (ctrl.clear) begin
         acc_in = init;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + SUM_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
      end else begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== sv/conv2d_output_point.sv =====
// Direct 2D convolution, one output point per compute request. A compute request reads N taps,
// N being the saturated input_channels * kernel_side^2, one tap read per cycle into one MAC,
// then drains the product and accumulator registers and issues the response; a bad index goes
// straight to the response. req_tready is high only in idle, and a response still waiting
// on rsp_tready holds off the next one. Reset is synchronous: configuration returns to its
// defaults and control clears; the image, weight and bias memories are not cleared.
module conv2d_output_point import c2op_pkg::*; #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_KERNEL       = 5,
   parameter int MAX_HEIGHT       = 32,
   parameter int MAX_WIDTH        = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: out_channel[3:0], in_channel[7:4], row[12:8], column[17:13], value[33:18], zeros
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: conv_sum[39:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser: bad_index[0]
   output logic [0:0]            rsp_tuser,
   // Configuration write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
   localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int OC_AW     = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
   localparam int CH_W      = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
   localparam int KC_W      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

   // Configuration registers.
   logic [4:0] input_channels_ff;
   logic [4:0] output_channels_ff;
   logic [2:0] kernel_side_ff;
   logic [2:0] step_size_ff;
   logic [2:0] zero_border_ff;
   logic [5:0] image_height_ff;
   logic [5:0] image_width_ff;
   logic       bias_enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_channels_ff  <= 5'd1;
         output_channels_ff <= 5'd1;
         kernel_side_ff     <= 3'd3;
         step_size_ff       <= 3'd1;
         zero_border_ff     <= 3'd1;
         image_height_ff    <= 6'd32;
         image_width_ff     <= 6'd32;
         bias_enable_ff     <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_CHANNELS:  input_channels_ff  <= csr_data[4:0];
            CSR_OUT_CHANNELS: output_channels_ff <= csr_data[4:0];
            CSR_KERNEL_SIDE:  kernel_side_ff     <= csr_data[2:0];
            CSR_STEP_SIZE:    step_size_ff       <= csr_data[2:0];
            CSR_ZERO_BORDER:  zero_border_ff     <= csr_data[2:0];
            CSR_IMAGE_HEIGHT: image_height_ff    <= csr_data[5:0];
            CSR_IMAGE_WIDTH:  image_width_ff     <= csr_data[5:0];
            CSR_BIAS_ENABLE:  bias_enable_ff     <= csr_data[0];
            default:          ;
         endcase
      end
   end

   // Effective settings: counts and sizes saturate to 1..maximum, stride below 1 acts as 1.
   logic [7:0] nic_eff;
   logic [7:0] noc_eff;
   logic [2:0] k_eff;
   logic [2:0] s_eff;
   logic [8:0] h_eff;
   logic [8:0] w_eff;

   always_comb begin
      nic_eff = (input_channels_ff == '0) ? 8'd1 :
                (32'(input_channels_ff) > 32'(MAX_IN_CHANNELS)) ? 8'(MAX_IN_CHANNELS) :
                8'(input_channels_ff);
      noc_eff = (output_channels_ff == '0) ? 8'd1 :
                (32'(output_channels_ff) > 32'(MAX_OUT_CHANNELS)) ? 8'(MAX_OUT_CHANNELS) :
                8'(output_channels_ff);
      k_eff   = (kernel_side_ff == '0) ? 3'd1 :
                (32'(kernel_side_ff) > 32'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_side_ff;
      s_eff   = (step_size_ff == '0) ? 3'd1 : step_size_ff;
      h_eff   = (image_height_ff == '0) ? 9'd1 :
                (32'(image_height_ff) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) :
                9'(image_height_ff);
      w_eff   = (image_width_ff == '0) ? 9'd1 :
                (32'(image_width_ff) > 32'(MAX_WIDTH)) ? 9'(MAX_WIDTH) :
                9'(image_width_ff);
   end

   // Request decode.
   req_fields_type req_f;
   opcode_type     req_op;
   logic           req_acc;

   assign req_f   = req_fields_type'(req_tdata[REQ_FIELDS_W-1:0]);
   assign req_op  = opcode_type'(req_tuser);
   assign req_acc = req_tvalid && req_tready;

   // Index check (output channel and window fit in the padded image) and the scaled window corner.
   logic [9:0]        row_scaled;
   logic [9:0]        col_scaled;
   logic [9:0]        h_limit;
   logic [9:0]        w_limit;
   logic              req_bad;

   always_comb begin
      row_scaled = 10'(req_f.row) * 10'(s_eff);
      col_scaled = 10'(req_f.column) * 10'(s_eff);
      h_limit    = 10'(h_eff) + 10'({zero_border_ff, 1'b0});
      w_limit    = 10'(w_eff) + 10'({zero_border_ff, 1'b0});
      req_bad    = (8'(req_f.out_channel) >= noc_eff) ||
                   (row_scaled + 10'(k_eff) > h_limit) ||
                   (col_scaled + 10'(k_eff) > w_limit);
   end

   // Sequencer registers.
   state_type          state_ff, state_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [KC_W-1:0]    kh_ff, kh_in;
   logic [KC_W-1:0]    kw_ff, kw_in;
   logic               drain_ff, drain_in;
   logic               first_ff, first_in;
   logic               bad_ff, bad_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic signed [9:0]  row_base_ff;
   logic signed [9:0]  col_base_ff;
   logic [3:0]         oc_ff;

   // Current tap position and its bounds check.
   logic signed [9:0]  ih;
   logic signed [9:0]  iw;
   logic               tap_ok;
   logic               last_tap;
   logic               rsp_free;

   always_comb begin
      ih       = row_base_ff + signed'(10'(kh_ff));
      iw       = col_base_ff + signed'(10'(kw_ff));
      tap_ok   = !ih[9] && (ih < signed'(10'(h_eff))) &&
                 !iw[9] && (iw < signed'(10'(w_eff)));
      last_tap = (8'(ch_ff) == nic_eff - 8'd1) &&
                 (3'(kh_ff) == k_eff - 3'd1) &&
                 (3'(kw_ff) == k_eff - 3'd1);
      rsp_free = !rsp_vld_ff || rsp_tready;
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Next-state logic: walk channels, kernel rows and kernel columns one tap per cycle.
   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      kh_in      = kh_ff;
      kw_in      = kw_ff;
      drain_in   = drain_ff;
      first_in   = 1'b0;
      bad_in     = bad_ff;
      rd_vld_in  = 1'b0;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_op == OP_COMPUTE)) begin
               ch_in  = '0;
               kh_in  = '0;
               kw_in  = '0;
               bad_in = req_bad;
               if (req_bad) begin
                  state_in = ST_WAIT;
               end else begin
                  first_in = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rd_vld_in = tap_ok;
            if (last_tap) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else if (3'(kw_ff) == k_eff - 3'd1) begin
               kw_in = '0;
               if (3'(kh_ff) == k_eff - 3'd1) begin
                  kh_in = '0;
                  ch_in = ch_ff + CH_W'(1);
               end else begin
                  kh_in = kh_ff + KC_W'(1);
               end
            end else begin
               kw_in = kw_ff + KC_W'(1);
            end
         end
         ST_DRAIN: begin
            // The drain brings the last read through the product register and into the accumulator.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ch_ff      <= '0;
         kh_ff      <= '0;
         kw_ff      <= '0;
         drain_ff   <= 1'b0;
         first_ff   <= 1'b0;
         bad_ff     <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ch_ff      <= ch_in;
         kh_ff      <= kh_in;
         kw_ff      <= kw_in;
         drain_ff   <= drain_in;
         first_ff   <= first_in;
         bad_ff     <= bad_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Window origin and output channel of the compute request.
   always_ff @(posedge clock) begin
      if (req_acc && (req_op == OP_COMPUTE)) begin
         row_base_ff <= signed'(row_scaled - 10'(zero_border_ff));
         col_base_ff <= signed'(col_scaled - 10'(zero_border_ff));
         oc_ff       <= req_f.out_channel;
      end
   end

   // Memory addresses for writes and for the tap being read.
   logic [IMG_AW-1:0] img_waddr;
   logic [IMG_AW-1:0] img_raddr;
   logic [WGT_AW-1:0] wgt_waddr;
   logic [WGT_AW-1:0] wgt_raddr;
   logic [OC_AW-1:0]  bias_waddr;
   logic              img_we;
   logic              wgt_we;
   logic              bias_we;
   logic              run_rd;

   always_comb begin
      img_waddr  = IMG_AW'((32'(req_f.in_channel) * MAX_HEIGHT + 32'(req_f.row)) * MAX_WIDTH
                           + 32'(req_f.column));
      img_raddr  = IMG_AW'((32'(ch_ff) * MAX_HEIGHT + 32'(ih[8:0])) * MAX_WIDTH
                           + 32'(iw[8:0]));
      wgt_waddr  = WGT_AW'(((32'(req_f.out_channel) * MAX_IN_CHANNELS
                            + 32'(req_f.in_channel)) * MAX_KERNEL + 32'(req_f.row))
                           * MAX_KERNEL + 32'(req_f.column));
      wgt_raddr  = WGT_AW'(((32'(oc_ff) * MAX_IN_CHANNELS + 32'(ch_ff)) * MAX_KERNEL
                            + 32'(kh_ff)) * MAX_KERNEL + 32'(kw_ff));
      bias_waddr = OC_AW'(req_f.out_channel);
      img_we     = req_acc && (req_op == OP_PIXEL) &&
                   (32'(req_f.in_channel) < 32'(MAX_IN_CHANNELS)) &&
                   (32'(req_f.row) < 32'(MAX_HEIGHT)) &&
                   (32'(req_f.column) < 32'(MAX_WIDTH));
      wgt_we     = req_acc && (req_op == OP_WEIGHT) &&
                   (32'(req_f.out_channel) < 32'(MAX_OUT_CHANNELS)) &&
                   (32'(req_f.in_channel) < 32'(MAX_IN_CHANNELS)) &&
                   (32'(req_f.row) < 32'(MAX_KERNEL)) &&
                   (32'(req_f.column) < 32'(MAX_KERNEL));
      bias_we    = req_acc && (req_op == OP_BIAS) &&
                   (32'(req_f.out_channel) < 32'(MAX_OUT_CHANNELS));
      run_rd     = (state_ff == ST_RUN) && tap_ok;
   end

   // Image memory: one write port from requests, one read port for the tap walk.
   logic signed [VALUE_W-1:0] img_mem [IMG_DEPTH];
   logic signed [VALUE_W-1:0] img_rd_ff;

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= req_f.value;
      end
      if (run_rd) begin
         img_rd_ff <= img_mem[img_raddr];
      end
   end

   // Weight memory.
   logic signed [VALUE_W-1:0] wgt_mem [WGT_DEPTH];
   logic signed [VALUE_W-1:0] wgt_rd_ff;

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_waddr] <= req_f.value;
      end
      if (run_rd) begin
         wgt_rd_ff <= wgt_mem[wgt_raddr];
      end
   end

   // Bias memory, read once when a compute request is accepted.
   logic signed [VALUE_W-1:0] bias_mem [MAX_OUT_CHANNELS];
   logic signed [VALUE_W-1:0] bias_rd_ff;

   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[bias_waddr] <= req_f.value;
      end
      if (req_acc && (req_op == OP_COMPUTE) && !req_bad) begin
         bias_rd_ff <= bias_mem[OC_AW'(req_f.out_channel)];
      end
   end

   // Multiply-accumulate; the bias is aligned to Q16.16 as the start value.
   mac_ctrl_type             mac_ctrl;
   logic signed [SUM_W-1:0]  mac_init;
   logic signed [SUM_W-1:0]  mac_acc;

   always_comb begin
      mac_ctrl.clear   = first_ff;
      mac_ctrl.tap_vld = rd_vld_ff;
      mac_ctrl.acc_en  = (state_ff == ST_RUN) || (state_ff == ST_DRAIN);
      mac_init         = bias_enable_ff ? (SUM_W'(bias_rd_ff) <<< 8) : '0;
   end

   c2op_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .pixel  (img_rd_ff),
      .weight (wgt_rd_ff),
      .init   (mac_init),
      .acc    (mac_acc)
   );

   // Response register.
   logic [RSP_DATA_W-1:0] rsp_sum_ff;
   logic                  rsp_bad_ff;

   always_ff @(posedge clock) begin
      if ((state_ff == ST_WAIT) && rsp_free) begin
         rsp_sum_ff <= bad_ff ? '0 : RSP_DATA_W'(mac_acc);
         rsp_bad_ff <= bad_ff;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_sum_ff;
   assign rsp_tuser[0] = rsp_bad_ff;

endmodule
